[design/asac_pkg.sv]
// Package: item kinds, character constants and armor/hex helpers for the AIS sentence core.
package asac_pkg;

	typedef enum logic [1:0] {
		KIND_START   = 2'd0,
		KIND_LITERAL = 2'd1,
		KIND_PAYLOAD = 2'd2,
		KIND_END     = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_HIGH = 3'b010,
		PH_LOW  = 3'b100
	} phase_t;

	localparam logic [7:0] CHAR_ASTERISK = 8'h2A;
	localparam logic [7:0] CHAR_ZERO     = 8'h30;
	localparam logic [7:0] HEX_ALPHA_OFS = 8'h37;
	localparam logic [7:0] ARMOR_LOW_OFS = 8'd48;
	localparam logic [7:0] ARMOR_HIGH_OFS = 8'd56;
	localparam logic [5:0] ARMOR_SPLIT   = 6'd40;
	localparam logic [3:0] HEX_SPLIT     = 4'd10;

	function automatic logic [7:0] armor_six(input logic [5:0] six);
		logic [7:0] ext;
		ext = {2'b00, six};
		armor_six = (six < ARMOR_SPLIT) ? ext + ARMOR_LOW_OFS : ext + ARMOR_HIGH_OFS;
	endfunction

	function automatic logic [7:0] hex_digit(input logic [3:0] nib);
		logic [7:0] ext;
		ext = {4'b0000, nib};
		hex_digit = (nib < HEX_SPLIT) ? ext + CHAR_ZERO : ext + HEX_ALPHA_OFS;
	endfunction

endpackage

[design/asac_item_if.sv]
// Interface: input item channel carrying kind and value words.
interface asac_item_if
	import asac_pkg::*;
();
	logic       valid;
	logic       ready;
	kind_t      kind;
	logic [7:0] value;

	modport source (output valid, output kind, output value, input ready);
	modport sink   (input valid, input kind, input value, output ready);
endinterface

[design/asac_char_if.sv]
// Interface: output character channel carrying character and last words.
interface asac_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] character;
	logic       last;

	modport source (output valid, output character, output last, input ready);
	modport sink   (input valid, input character, input last, output ready);
endinterface

[design/ais_sentence_armor_checksum_core.sv]
// Top level: AIS sentence character generator with six-bit armor and running XOR checksum.
//
// Takes one item word per cycle and emits one character word per cycle while the receiver
// is ready and no checksum digits are pending. Start, literal and payload items each give
// one character in the cycle after acceptance. An end item gives three characters ('*',
// then the checksum as two uppercase hex digits); the single output register emits the
// hex digits from the checksum register, so the item channel is held off until both digits
// are issued, and for longer while the character receiver stalls. The output register lets
// a new item be taken in the same cycle the pending character is taken.
module ais_sentence_armor_checksum_core
	import asac_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	asac_item_if.sink   items,
	asac_char_if.source chars
);

	logic [7:0] xor_q;
	logic       out_valid_q;
	logic [7:0] out_char_q;
	logic       out_last_q;
	phase_t     phase_q;

	logic       advance;
	logic       accept;
	logic [7:0] item_char;

	assign advance     = !out_valid_q || chars.ready;
	assign items.ready = advance && (phase_q == PH_IDLE);
	assign accept      = items.valid && items.ready;

	always_comb begin
		case (items.kind)
			KIND_PAYLOAD: item_char = armor_six(items.value[5:0]);
			KIND_END:     item_char = CHAR_ASTERISK;
			default:      item_char = items.value;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xor_q       <= '0;
			out_valid_q <= 1'b0;
			phase_q     <= PH_IDLE;
		end else if (advance) begin
			case (phase_q)
				PH_HIGH: begin
					out_valid_q <= 1'b1;
					phase_q     <= PH_LOW;
				end
				PH_LOW: begin
					out_valid_q <= 1'b1;
					phase_q     <= PH_IDLE;
				end
				default: begin
					out_valid_q <= accept;
					if (accept) begin
						case (items.kind)
							KIND_START:   xor_q   <= '0;
							KIND_END:     phase_q <= PH_HIGH;
							default:      xor_q   <= xor_q ^ item_char;
						endcase
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			case (phase_q)
				PH_HIGH: begin
					out_char_q <= hex_digit(xor_q[7:4]);
					out_last_q <= 1'b0;
				end
				PH_LOW: begin
					out_char_q <= hex_digit(xor_q[3:0]);
					out_last_q <= 1'b1;
				end
				default: begin
					out_char_q <= item_char;
					out_last_q <= (items.kind != KIND_END);
				end
			endcase
		end
	end

	assign chars.valid     = out_valid_q;
	assign chars.character = out_char_q;
	assign chars.last      = out_last_q;

	a_hold_off: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_IDLE) |-> !items.ready)
		else $error("item taken while checksum digits pending");

	a_end_star: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && items.kind == KIND_END) |=>
			(chars.valid && chars.character == CHAR_ASTERISK && !chars.last))
		else $error("end item did not emit asterisk");

	a_more_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(chars.valid && chars.ready && !chars.last) |=> chars.valid)
		else $error("gap inside end sequence");

	a_start_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && items.kind == KIND_START) |=> (xor_q == 8'h00))
		else $error("start item did not clear checksum");

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps
// Testbench: directed and random AIS sentence words, character stream checked against a predictor.
module tb;
	import asac_pkg::*;

	localparam int ITEM_TARGET = 480;
	localparam int CALM_FROM   = 400;
	localparam int HOLD_AFTER  = 150;
	localparam int LONG_HOLD   = 80;
	localparam int STALL_LIMIT = 1000;
	localparam int REPORT_MAX  = 10;
	localparam int DRAIN_WAIT  = 12;

	typedef struct packed {
		logic [7:0] character;
		logic       last;
	} char_word_t;

	class sentence_predictor;
		logic [7:0] checksum;
		char_word_t expected_chars[$];
		int         kind_seen[4];
		int         chars_checked;
		int         mismatches;

		function new();
			checksum = '0;
			chars_checked = 0;
			mismatches = 0;
			foreach (kind_seen[i]) kind_seen[i] = 0;
		endfunction

		function logic [7:0] armored(input logic [7:0] v);
			logic [7:0] six;
			six = {2'b00, v[5:0]};
			return (six >= 8'd40) ? six + 8'd56 : six + 8'd48;
		endfunction

		function logic [7:0] hex_char(input logic [3:0] n);
			return (n > 4'd9) ? 8'h41 + {4'b0000, n} - 8'd10 : 8'h30 + {4'b0000, n};
		endfunction

		function void push(input logic [7:0] c, input logic l);
			char_word_t w;
			w.character = c;
			w.last = l;
			expected_chars.push_back(w);
		endfunction

		function void note_item(input kind_t k, input logic [7:0] v);
			logic [7:0] ch;
			kind_seen[int'(k)]++;
			case (k)
				KIND_START: begin
					checksum = '0;
					push(v, 1'b1);
				end
				KIND_LITERAL: begin
					checksum ^= v;
					push(v, 1'b1);
				end
				KIND_PAYLOAD: begin
					ch = armored(v);
					checksum ^= ch;
					push(ch, 1'b1);
				end
				default: begin
					push(CHAR_ASTERISK, 1'b0);
					push(hex_char(checksum[7:4]), 1'b0);
					push(hex_char(checksum[3:0]), 1'b1);
				end
			endcase
		endfunction

		function void check_char(input logic [7:0] c, input logic l);
			char_word_t want;
			chars_checked++;
			if (expected_chars.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("mismatch at %0t: no character expected, got char %h last %b",
						$time, c, l);
			end else begin
				want = expected_chars.pop_front();
				if (want.character !== c || want.last !== l) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("mismatch at %0t: expected char %h last %b, got char %h last %b",
							$time, want.character, want.last, c, l);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   items_sent;
	int   items_taken;
	int   idle_cycles;
	bit   hold_done;

	sentence_predictor model;

	asac_item_if items();
	asac_char_if chars();

	ais_sentence_armor_checksum_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.items  (items),
		.chars  (chars)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// acceptance monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (chars.valid && chars.ready) model.check_char(chars.character, chars.last);
			if (items.valid && items.ready) begin
				model.note_item(items.kind, items.value);
				items_taken++;
			end
			if ((chars.valid && chars.ready) || (items.valid && items.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("watchdog: no word accepted for %0d cycles", STALL_LIMIT);
				$display("ais_sentence_armor_checksum_core regression: fail");
				$finish;
			end
		end
	end

	// receiver: random stalls, one long hold, none at the end
	initial begin
		chars.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (!hold_done && items_taken >= HOLD_AFTER) begin
				chars.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_done = 1'b1;
			end else if (items_sent < CALM_FROM && $urandom_range(0, 3) == 0) begin
				chars.ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end else begin
				chars.ready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	task automatic send_item(input kind_t k, input logic [7:0] v);
		items.valid <= 1'b1;
		items.kind  <= k;
		items.value <= v;
		@(posedge clk);
		while (!items.ready) @(posedge clk);
		items_sent++;
		if (items_sent < CALM_FROM && $urandom_range(0, 3) == 0) begin
			items.valid <= 1'b0;
			items.kind  <= kind_t'($urandom_range(0, 3));
			items.value <= 8'($urandom);
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	task automatic send_sentence();
		string      header;
		int         n_head;
		int         n_pay;
		logic [7:0] lead;
		header = "AIVDM,1,1,,A,";
		lead = ($urandom_range(0, 3) == 0) ? 8'h24 : 8'h21;
		if ($urandom_range(0, 7) == 0) lead = 8'($urandom);
		send_item(KIND_START, lead);
		n_head = $urandom_range(2, header.len());
		for (int i = 0; i < n_head; i++) begin
			if ($urandom_range(0, 9) == 0)
				send_item(KIND_LITERAL, 8'($urandom));
			else
				send_item(KIND_LITERAL, header[i]);
		end
		n_pay = $urandom_range(1, 16);
		for (int i = 0; i < n_pay; i++) send_item(KIND_PAYLOAD, 8'($urandom));
		if ($urandom_range(0, 1) == 0) begin
			send_item(KIND_LITERAL, 8'h2C);
			send_item(KIND_LITERAL, 8'h30 + 8'($urandom_range(0, 5)));
		end
		send_item(KIND_END, 8'($urandom));
	endtask

	initial begin
		model = new();
		items_sent = 0;
		items_taken = 0;
		idle_cycles = 0;
		hold_done = 1'b0;
		arst_n <= 1'b0;
		items.valid <= 1'b0;
		items.kind  <= KIND_START;
		items.value <= 8'h00;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// end straight after reset, field extremes, payload high bits, literal asterisk
		send_item(KIND_END, 8'hFF);
		send_item(KIND_START, 8'hFF);
		send_item(KIND_LITERAL, 8'h00);
		send_item(KIND_LITERAL, 8'hFF);
		send_item(KIND_PAYLOAD, 8'h00);
		send_item(KIND_PAYLOAD, 8'h27);
		send_item(KIND_PAYLOAD, 8'h28);
		send_item(KIND_PAYLOAD, 8'h3F);
		send_item(KIND_PAYLOAD, 8'hC0);
		send_item(KIND_PAYLOAD, 8'hFF);
		send_item(KIND_LITERAL, CHAR_ASTERISK);
		send_item(KIND_END, 8'h00);
		// keep summing after end, then restart
		send_item(KIND_LITERAL, 8'h41);
		send_item(KIND_END, 8'h55);
		send_item(KIND_START, 8'h00);
		send_item(KIND_START, 8'h21);
		send_item(KIND_LITERAL, 8'h41);
		send_item(KIND_LITERAL, 8'h49);
		send_item(KIND_LITERAL, 8'h2C);
		send_item(KIND_PAYLOAD, 8'h15);
		send_item(KIND_END, 8'hAA);

		while (items_sent < ITEM_TARGET) begin
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 4))
					send_item(kind_t'($urandom_range(0, 3)), 8'($urandom));
			end else begin
				send_sentence();
			end
		end
		items.valid <= 1'b0;

		while (model.expected_chars.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("covered %0d words: %0d start, %0d literal, %0d payload, %0d end",
			items_taken, model.kind_seen[0], model.kind_seen[1],
			model.kind_seen[2], model.kind_seen[3]);
		$display("%0d characters checked across random stalls and one long hold, %0d mismatches",
			model.chars_checked, model.mismatches);
		if (model.mismatches == 0 && model.expected_chars.size() == 0) begin
			$display("ais_sentence_armor_checksum_core regression: pass");
		end else begin
			$display("ais_sentence_armor_checksum_core regression: fail");
		end
		$finish;
	end

endmodule

[filelist.f]
design/asac_pkg.sv
design/asac_item_if.sv
design/asac_char_if.sv
design/ais_sentence_armor_checksum_core.sv
verif/tb.sv
